// ----- src/lcae_pkg.sv -----
// Shared types, constants and helper functions of the LED cube animation engine.
`default_nettype none

package lcae_pkg;

  // Image store geometry.
  localparam int IMAGE_BYTES = 64;
  localparam int ADDR_W      = 6;
  localparam int LAYER_BYTES = 8;

  // Command codes carried on the input tuser field.
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_RUN    = 3'd1,
    CMD_BUTTON = 3'd2,
    CMD_SELECT = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // Animation indexes.
  localparam logic [1:0] MODE_RANDOM_RAIN   = 2'd0;
  localparam logic [1:0] MODE_VERTICAL_RAIN = 2'd1;
  localparam logic [1:0] MODE_PLANES        = 2'd2;
  localparam logic [1:0] MODE_LED_TEST      = 2'd3;

  // Plane directions.
  localparam logic [1:0] DIR_X = 2'd0;
  localparam logic [1:0] DIR_Y = 2'd1;
  localparam logic [1:0] DIR_Z = 2'd2;

  // Reset values and constants.
  localparam logic [7:0]  LFSR_SEED      = 8'hA6;
  localparam logic [7:0]  LFSR_TAPS      = 8'hB8;
  localparam logic [7:0]  BLANK_BYTE     = 8'hFF;
  localparam logic [7:0]  LIT_BYTE       = 8'h00;
  localparam logic [6:0]  RAIN_STEP_LAST = 7'd64;
  localparam logic [15:0] FRAME_MAX      = 16'hFFFF;
  localparam logic [15:0] RST_RANDOM_RAIN_INTERVAL   = 16'd5;
  localparam logic [15:0] RST_VERTICAL_RAIN_INTERVAL = 16'd15;
  localparam logic [15:0] RST_PLANES_INTERVAL        = 16'd60;
  localparam logic [15:0] RST_LED_TEST_INTERVAL      = 16'd60;

  // Byte with a single LED lit (active low).
  function automatic logic [7:0] low_mask(input logic [2:0] bit_idx);
    logic [7:0] m;
    m = 8'hFF;
    m[bit_idx] = 1'b0;
    return m;
  endfunction

  // One step of the 8-bit Galois LFSR.
  function automatic logic [7:0] lfsr_next(input logic [7:0] cur);
    logic [7:0] t;
    t = {1'b0, cur[7:1]};
    if (cur[0]) begin
      t = t ^ LFSR_TAPS;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- src/lcae_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lcae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/led_cube_animation_engine_unit.sv -----
// Top level of the LED cube animation engine: command sequencer and image store.
//
// Commands arrive on the s_axis channel: the command code in tuser, its
// arguments in tdata. A read command returns one result on m_axis: the
// addressed image byte together with the animation status. Other commands
// return nothing. Configuration writes set the four step intervals.
//
// Tick, buttons, ignored codes, planes or test select end in the idle state.
// A read fetches the byte, then waits until the output register is free.
// Rain select fills the store. A run whose interval has not been reached
// does nothing; a random rain step shifts the store up a layer, blanks the
// bottom layer and lights DROPS_PER_FRAME drops, a vertical rain step
// shifts, blanks and marks one byte, and a planes or test step refills the
// store, all through the single store write port, one byte per cycle.
//
// After reset the sequencer sweeps the store to all LEDs off, with
// s_axis_tready low. A stalled receiver holds a read in the output
// register; the next command is still taken, and a following read waits.
`default_nettype none

module led_cube_animation_engine_unit #(
  parameter int DROPS_PER_FRAME = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command channel.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: button_left[0], button_right[1], anim_select[9:2], byte_address[15:10]
  input  wire logic [15:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // Result channel.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: image_byte[7:0], active_anim[9:8], plane_direction[11:10],
  //        plane_position[14:12], test_column[17:15], test_row_bit[20:18],
  //        test_layer[23:21]
  output logic      [23:0] m_axis_tdata,
  // Configuration port.
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int DROP_W = $clog2(DROPS_PER_FRAME + 1);
  localparam logic [DROP_W-1:0] DROP_LAST = DROP_W'(DROPS_PER_FRAME - 1);
  localparam int AW = lcae_pkg::ADDR_W;
  localparam logic [AW-1:0] SHIFT_FIRST = AW'(lcae_pkg::IMAGE_BYTES - lcae_pkg::LAYER_BYTES - 1);
  localparam logic [AW-1:0] SHIFT_LAST  = AW'(lcae_pkg::IMAGE_BYTES - lcae_pkg::LAYER_BYTES);
  localparam logic [AW-1:0] TOP_LAST    = AW'(lcae_pkg::LAYER_BYTES - 1);
  localparam logic [AW-1:0] FILL_LAST   = AW'(lcae_pkg::IMAGE_BYTES - 1);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_FILL      = 8'b0000_0010,
    ST_SHIFT     = 8'b0000_0100,
    ST_TOP       = 8'b0000_1000,
    ST_DROP_RD   = 8'b0001_0000,
    ST_DROP_WR   = 8'b0010_0000,
    ST_RAIN_MARK = 8'b0100_0000,
    ST_READ      = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    FILL_BLANK  = 2'd0,
    FILL_PLANES = 2'd1,
    FILL_TEST   = 2'd2
  } fill_kind_t;

  state_t              state;
  fill_kind_t          fill_kind;
  logic [AW-1:0]       cnt;
  logic [DROP_W-1:0]   drop_cnt;
  logic [2:0]          drop_addr;
  logic [2:0]          drop_bit;
  logic [AW-1:0]       read_addr;
  logic                read_wait;
  logic [15:0]         intervals [4];
  logic [1:0]          anim_mode;
  logic [15:0]         frame_count;
  logic [7:0]          lfsr_value;
  logic [6:0]          rain_step;
  logic [1:0]          plane_dir_reg;
  logic [2:0]          plane_idx_reg;
  logic [2:0]          test_col_reg;
  logic [2:0]          test_row_reg;
  logic [2:0]          test_layer_reg;

  // Input field unpacking.
  logic [2:0]          in_cmd;
  logic                in_left;
  logic                in_right;
  logic [7:0]          in_sel;
  logic [AW-1:0]       in_addr;
  logic                in_xfer;
  logic                out_free;
  logic                out_load;

  assign in_cmd   = s_axis_tuser;
  assign in_left  = s_axis_tdata[0];
  assign in_right = s_axis_tdata[1];
  assign in_sel   = s_axis_tdata[9:2];
  assign in_addr  = s_axis_tdata[15:10];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // The fetched byte moves into the output register once that register is free.
  assign out_load      = (state == ST_READ) && read_wait && out_free;

  // Image store port signals.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    lfsr_step;
  logic [7:0]    fill_byte;

  assign lfsr_step = lcae_pkg::lfsr_next(lfsr_value);

  lcae_ram #(
    .WIDTH (8),
    .DEPTH (lcae_pkg::IMAGE_BYTES)
  ) u_image (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Byte written at the current sweep address during a full-store fill.
  always_comb begin
    fill_byte = lcae_pkg::BLANK_BYTE;
    case (fill_kind)
      FILL_PLANES: begin
        case (plane_dir_reg)
          lcae_pkg::DIR_X: begin
            if (cnt[5:3] == plane_idx_reg) fill_byte = lcae_pkg::LIT_BYTE;
          end
          lcae_pkg::DIR_Y: begin
            if (cnt[2:0] == plane_idx_reg) fill_byte = lcae_pkg::LIT_BYTE;
          end
          lcae_pkg::DIR_Z: begin
            fill_byte = lcae_pkg::low_mask(plane_idx_reg);
          end
          default: begin
            fill_byte = lcae_pkg::BLANK_BYTE;
          end
        endcase
      end
      FILL_TEST: begin
        if (cnt == {test_layer_reg, test_col_reg}) begin
          fill_byte = lcae_pkg::low_mask(test_row_reg);
        end
      end
      default: begin
        fill_byte = lcae_pkg::BLANK_BYTE;
      end
    endcase
  end

  // Store port control by sequencer state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = lcae_pkg::BLANK_BYTE;
    rd_addr = read_addr;
    case (state)
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_data = fill_byte;
      end
      ST_SHIFT: begin
        // Read runs one byte ahead of the write, eight bytes lower.
        rd_addr = AW'(SHIFT_FIRST - cnt);
        wr_en   = (cnt != '0);
        wr_addr = AW'('0 - cnt);
        wr_data = rd_data;
      end
      ST_TOP: begin
        wr_en = 1'b1;
      end
      ST_DROP_RD: begin
        rd_addr = {3'b000, lfsr_step[2:0]};
      end
      ST_DROP_WR: begin
        wr_en   = 1'b1;
        wr_addr = {3'b000, drop_addr};
        wr_data = rd_data & lcae_pkg::low_mask(drop_bit);
      end
      ST_RAIN_MARK: begin
        wr_en   = 1'b1;
        wr_addr = {2'b00, rain_step[6:3]};
        wr_data = lcae_pkg::low_mask(rain_step[2:0]);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      intervals[0] <= lcae_pkg::RST_RANDOM_RAIN_INTERVAL;
      intervals[1] <= lcae_pkg::RST_VERTICAL_RAIN_INTERVAL;
      intervals[2] <= lcae_pkg::RST_PLANES_INTERVAL;
      intervals[3] <= lcae_pkg::RST_LED_TEST_INTERVAL;
    end else if (cfg_wen) begin
      intervals[cfg_index] <= cfg_data;
    end
  end

  // Sequencer and animation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_FILL;
      fill_kind      <= FILL_BLANK;
      cnt            <= '0;
      drop_cnt       <= '0;
      read_wait      <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      anim_mode      <= lcae_pkg::MODE_RANDOM_RAIN;
      frame_count    <= '0;
      lfsr_value     <= lcae_pkg::LFSR_SEED;
      rain_step      <= '0;
      plane_dir_reg  <= lcae_pkg::DIR_X;
      plane_idx_reg  <= '0;
      test_col_reg   <= '0;
      test_row_reg   <= '0;
      test_layer_reg <= '0;
    end else begin
      // Result register: load a fetched read, or drop a finished transfer.
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {test_layer_reg, test_row_reg, test_col_reg, plane_idx_reg,
                          plane_dir_reg, anim_mode, rd_data};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt <= '0;
            case (in_cmd)
              lcae_pkg::CMD_TICK: begin
                if (frame_count != lcae_pkg::FRAME_MAX) frame_count <= frame_count + 16'd1;
              end
              lcae_pkg::CMD_RUN: begin
                if (frame_count >= intervals[anim_mode]) begin
                  frame_count <= '0;
                  case (anim_mode)
                    lcae_pkg::MODE_RANDOM_RAIN: begin
                      state <= ST_SHIFT;
                    end
                    lcae_pkg::MODE_VERTICAL_RAIN: begin
                      rain_step <= (rain_step >= lcae_pkg::RAIN_STEP_LAST) ? '0
                                                                           : rain_step + 7'd1;
                      state     <= ST_SHIFT;
                    end
                    lcae_pkg::MODE_PLANES: begin
                      plane_idx_reg <= plane_idx_reg + 3'd1;
                      fill_kind     <= FILL_PLANES;
                      state         <= ST_FILL;
                    end
                    default: begin
                      test_layer_reg <= test_layer_reg + 3'd1;
                      fill_kind      <= FILL_TEST;
                      state          <= ST_FILL;
                    end
                  endcase
                end
              end
              lcae_pkg::CMD_BUTTON: begin
                if (anim_mode == lcae_pkg::MODE_PLANES) begin
                  if (in_left) begin
                    plane_dir_reg <= (plane_dir_reg == lcae_pkg::DIR_Z) ? lcae_pkg::DIR_X
                                                                        : plane_dir_reg + 2'd1;
                  end
                  if (in_right) plane_idx_reg <= plane_idx_reg + 3'd1;
                end else if (anim_mode == lcae_pkg::MODE_LED_TEST) begin
                  if (in_left)  test_col_reg <= test_col_reg + 3'd1;
                  if (in_right) test_row_reg <= test_row_reg + 3'd1;
                end
              end
              lcae_pkg::CMD_SELECT: begin
                if (in_sel[7:2] == '0) begin
                  anim_mode <= in_sel[1:0];
                  case (in_sel[1:0])
                    lcae_pkg::MODE_RANDOM_RAIN: begin
                      fill_kind <= FILL_BLANK;
                      state     <= ST_FILL;
                    end
                    lcae_pkg::MODE_VERTICAL_RAIN: begin
                      rain_step <= '0;
                      fill_kind <= FILL_BLANK;
                      state     <= ST_FILL;
                    end
                    lcae_pkg::MODE_PLANES: begin
                      plane_dir_reg <= lcae_pkg::DIR_X;
                      plane_idx_reg <= '0;
                    end
                    default: begin
                      test_col_reg   <= '0;
                      test_row_reg   <= '0;
                      test_layer_reg <= '0;
                    end
                  endcase
                end
              end
              lcae_pkg::CMD_READ: begin
                read_addr <= in_addr;
                read_wait <= 1'b0;
                state     <= ST_READ;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        // Full-store write, one byte per cycle.
        ST_FILL: begin
          cnt <= cnt + AW'(1);
          if (cnt == FILL_LAST) state <= ST_IDLE;
        end

        // Move bytes 0..55 up by one layer, top byte first.
        ST_SHIFT: begin
          if (cnt == SHIFT_LAST) begin
            cnt   <= '0;
            state <= ST_TOP;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end

        // Blank the bottom layer.
        ST_TOP: begin
          cnt <= cnt + AW'(1);
          if (cnt == TOP_LAST) begin
            drop_cnt <= '0;
            state    <= (anim_mode == lcae_pkg::MODE_RANDOM_RAIN) ? ST_DROP_RD : ST_RAIN_MARK;
          end
        end

        // Draw a random drop position and fetch its byte.
        ST_DROP_RD: begin
          lfsr_value <= lfsr_step;
          drop_addr  <= lfsr_step[2:0];
          drop_bit   <= lfsr_step[6:4];
          state      <= ST_DROP_WR;
        end

        // Light the drop in the fetched byte.
        ST_DROP_WR: begin
          drop_cnt <= drop_cnt + DROP_W'(1);
          state    <= (drop_cnt == DROP_LAST) ? ST_IDLE : ST_DROP_RD;
        end

        ST_RAIN_MARK: begin
          state <= ST_IDLE;
        end

        // Fetch the byte, then wait for the output register to be free.
        ST_READ: begin
          read_wait <= 1'b1;
          if (out_load) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/lcae_checker.sv -----
// Port-level assertions for the LED cube animation engine, bound to its top level.
`default_nettype none

module lcae_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        cfg_wen
);

  logic in_xfer;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Reset starts the clearing sweep, so no command is taken right after it.
  a_reset_sweep: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("command channel ready right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Only a read transfer may produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_axis_tuser != lcae_pkg::CMD_READ) && !m_axis_tvalid && !cfg_wen
    |=> !m_axis_tvalid)
    else $error("result produced by a command other than read");

  // A read occupies the sequencer while the byte is fetched.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_axis_tuser == lcae_pkg::CMD_READ) |=> !s_axis_tready)
    else $error("command taken during store fetch");

  // Selecting random rain starts a store fill.
  a_select_fill: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_axis_tuser == lcae_pkg::CMD_SELECT) && (s_axis_tdata[9:2] == 8'd0)
    |=> !s_axis_tready)
    else $error("command taken during store fill");

endmodule

bind led_cube_animation_engine_unit lcae_port_checks u_port_checks (.*);

`default_nettype wire
